[rtl/bch_pkg.sv]
// Package with the BCH generator polynomial, widths and the byte-wide LFSR step.
`default_nettype none
package bch_pkg;

  localparam int DATA_W       = 8;
  localparam int REM_W        = 144;
  localparam int PARITY_BYTES = REM_W / DATA_W;
  localparam int PCNT_W       = $clog2(PARITY_BYTES + 1);

  // Low 144 coefficients of g(x), x^143 down to x^0; x^144 is implicit
  localparam logic [REM_W-1:0] GEN_LOW =
    144'h2b6bd0545db3_4c1e01d5296e_58c8ed2701ad;

  typedef logic [REM_W-1:0]  rem_t;
  typedef logic [DATA_W-1:0] byte_t;
  typedef logic [PCNT_W-1:0] pcnt_t;

  // Advance the remainder by one byte, MSB first
  function automatic rem_t lfsr_byte(input rem_t rem_in, input byte_t din);
    rem_t rem;
    logic fb;
    rem = rem_in;
    for (int b = DATA_W - 1; b >= 0; b--) begin
      fb  = rem[REM_W-1] ^ din[b];
      rem = {rem[REM_W-2:0], 1'b0};
      if (fb) begin
        rem = rem ^ GEN_LOW;
      end
    end
    return rem;
  endfunction

endpackage
`default_nettype wire

[rtl/bch_if.sv]
// Valid/ready channel interfaces for message bytes and parity bytes.
`default_nettype none
interface bch_in_if;
  logic                 valid;
  logic                 ready;
  logic [bch_pkg::DATA_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface bch_out_if;
  logic                 valid;
  logic                 ready;
  logic [bch_pkg::DATA_W-1:0] parity_byte;
  logic                 last_parity;

  modport source (output valid, output parity_byte, output last_parity, input ready);
  modport sink   (input valid, input parity_byte, input last_parity, output ready);
endinterface
`default_nettype wire

[rtl/bch_parity_encoder.sv]
// Systematic BCH encoder over GF(2^9), t=16: message bytes in, 18 parity bytes out.
`default_nettype none
// The block takes MESSAGE_BYTES message bytes, one per transfer, MSB first, and
// folds each into a 144-bit remainder register in the cycle it is accepted.
// When the last byte of a block is taken, the updated remainder is copied into
// an output shift register that sends 18 parity bytes, most significant first,
// one per cycle while out_ch.ready is high, with last_parity on the final byte.
// The next block's bytes are accepted while the burst drains; only the byte that
// ends a block waits until the previous burst is down to its final transfer.
// Full throughput is therefore set by the one-byte-wide parity output port
// whenever MESSAGE_BYTES is below 18, as at the default size of 16 bytes.
module bch_parity_encoder #(
  parameter int MESSAGE_BYTES = 16
) (
  input  wire           clk,
  input  wire           rst_n,
  bch_in_if.sink        in_ch,
  bch_out_if.source     out_ch
);
  import bch_pkg::*;

  localparam int CNT_W = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MESSAGE_BYTES - 1);

  rem_t              rem_r, rem_nxt;
  rem_t              par_r, par_nxt;
  pcnt_t             pcnt_r, pcnt_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic in_xfer, out_xfer, block_end, burst_free;
  rem_t rem_upd;

  // Handshakes: the block-ending byte needs the parity register free
  assign burst_free   = (pcnt_r == '0) || ((pcnt_r == pcnt_t'(1)) && out_ch.ready);
  assign block_end    = (cnt_r == CNT_LAST);
  assign in_ch.ready  = !block_end || burst_free;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_xfer     = out_ch.valid && out_ch.ready;

  // Remainder update for one byte
  assign rem_upd = lfsr_byte(rem_r, in_ch.data_byte);

  always_comb begin
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    par_nxt  = par_r;
    pcnt_nxt = pcnt_r;
    // drain one parity byte
    if (out_xfer) begin
      par_nxt  = {par_r[REM_W-DATA_W-1:0], {DATA_W{1'b0}}};
      pcnt_nxt = pcnt_r - pcnt_t'(1);
    end
    if (in_xfer) begin
      if (block_end) begin
        rem_nxt  = '0;
        cnt_nxt  = '0;
        par_nxt  = rem_upd;
        pcnt_nxt = pcnt_t'(PARITY_BYTES);
      end else begin
        rem_nxt = rem_upd;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      cnt_r  <= '0;
      pcnt_r <= '0;
    end else begin
      rem_r  <= rem_nxt;
      cnt_r  <= cnt_nxt;
      pcnt_r <= pcnt_nxt;
    end
  end

  // Parity shift register carries payload only
  always_ff @(posedge clk) begin
    par_r <= par_nxt;
  end

  // Output channel
  assign out_ch.valid       = (pcnt_r != '0);
  assign out_ch.parity_byte = par_r[REM_W-1 -: DATA_W];
  assign out_ch.last_parity = (pcnt_r == pcnt_t'(1));

`ifndef SYNTHESIS
  // Byte counter stays inside the block
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_LAST)
    else $error("byte counter past end of block");

  // Ending byte always starts a full parity burst
  a_burst_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && block_end) |=> (pcnt_r == pcnt_t'(PARITY_BYTES)) && (rem_r == '0))
    else $error("parity burst not loaded at end of block");

  // Burst count never exceeds the parity length
  a_pcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= pcnt_t'(PARITY_BYTES))
    else $error("parity count out of range");

  // A stalled final byte keeps its last flag
  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.last_parity && !out_ch.ready) |=> out_ch.last_parity)
    else $error("last parity byte dropped while stalled");
`endif

endmodule
`default_nettype wire
